FILE: rtl/bqs_pkg.sv
package bqs_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 32;
   localparam int CHAN_W   = 3;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int DELAY_W  = 56;
   localparam int ACC_W    = DELAY_W + 2;
   localparam int FRAC_SH  = 24;
   localparam int NUM_COEFS = 5;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W   = 4;

   typedef logic [STEP_W-1:0] step_type;

   typedef struct packed {
      logic [CHAN_W-1:0]          chan_index;
      logic signed [SAMPLE_W-1:0] sample_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]          chan_out;
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       overflowed;
   } rsp_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_idx_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_P_Z1,
      ACC_P_Z2,
      ACC_P
   } acc_op_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_OOR,
      JMP_OVF
   } jmp_type;

   typedef struct packed {
      logic         opd_y;
      coef_idx_type coef_sel;
      acc_op_type   acc_op;
      logic         mem_rd;
      logic         cap_y;
      logic         wr_z1;
      logic         wr_z2;
      logic         wr_zero;
      jmp_type      jmp;
      step_type     jmp_tgt;
      logic         fin;
      logic         fin_zero;
      logic         fin_ovf;
   } ucode_type;

   typedef struct packed {
      logic in_range;
      logic ovf;
   } cond_type;

   localparam step_type STEP_B0X   = 4'd0;
   localparam step_type STEP_Z1    = 4'd1;
   localparam step_type STEP_CHK   = 4'd2;
   localparam step_type STEP_A1Y   = 4'd3;
   localparam step_type STEP_WR1   = 4'd4;
   localparam step_type STEP_A2Y   = 4'd5;
   localparam step_type STEP_WR2   = 4'd6;
   localparam step_type STEP_CLEAR = 4'd7;
   localparam step_type STEP_OOR   = 4'd8;

   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      w = '0;
      w.coef_sel = COEF_B0;
      w.acc_op   = ACC_HOLD;
      w.jmp      = JMP_NONE;
      w.jmp_tgt  = STEP_B0X;
      unique case (step)
         STEP_B0X: begin
            w.coef_sel = COEF_B0;
            w.mem_rd   = 1'b1;
            w.jmp      = JMP_OOR;
            w.jmp_tgt  = STEP_OOR;
         end
         STEP_Z1: begin
            w.acc_op   = ACC_P_Z1;
            w.coef_sel = COEF_B1;
         end
         STEP_CHK: begin
            w.cap_y   = 1'b1;
            w.acc_op  = ACC_P_Z2;
            w.jmp     = JMP_OVF;
            w.jmp_tgt = STEP_CLEAR;
         end
         STEP_A1Y: begin
            w.opd_y    = 1'b1;
            w.coef_sel = COEF_A1;
         end
         STEP_WR1: begin
            w.wr_z1    = 1'b1;
            w.coef_sel = COEF_B2;
         end
         STEP_A2Y: begin
            w.acc_op   = ACC_P;
            w.opd_y    = 1'b1;
            w.coef_sel = COEF_A2;
         end
         STEP_WR2: begin
            w.wr_z2 = 1'b1;
            w.fin   = 1'b1;
         end
         STEP_CLEAR: begin
            w.wr_zero  = 1'b1;
            w.fin      = 1'b1;
            w.fin_zero = 1'b1;
            w.fin_ovf  = 1'b1;
         end
         STEP_OOR: begin
            w.fin      = 1'b1;
            w.fin_zero = 1'b1;
         end
         default: begin
            w.fin      = 1'b1;
            w.fin_zero = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/bqs_sequencer.sv
module bqs_sequencer
   import bqs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic      advance,
   input  cond_type  cond,
   output logic      busy,
   output ucode_type ctl
);

   logic     busy_ff, busy_in;
   step_type step_ff, step_in;
   logic     take_jmp;

   assign ctl  = ucode_rom(step_ff);
   assign busy = busy_ff;

   always_comb begin
      unique case (ctl.jmp)
         JMP_OOR: take_jmp = !cond.in_range;
         JMP_OVF: take_jmp = cond.ovf;
         default: take_jmp = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_B0X;
      end else if (advance) begin
         if (ctl.fin) begin
            busy_in = 1'b0;
         end else if (take_jmp) begin
            step_in = ctl.jmp_tgt;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_B0X;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

FILE: rtl/biquad_filter_section_core.sv
// Biquad section, transposed direct form II, with per-channel delay state.
// Request channel: req_valid/req_ready carry a channel index and a Q4.20
// sample. Response channel: rsp_valid/rsp_ready return the channel, the
// Q4.20 output and an overflow flag, one response per request, in order.
// CSR channel: csr_valid/csr_ready (always ready) write coefficient
// b0, b1, b2, a1, a2 at index 0..4; other indexes are ignored. Write
// coefficients only while no request is in flight.
// Processing: a request is handled by a microcoded sequence driving one
// 24x32 multiplier and one accumulator. An overflowed sample and an
// out-of-range channel end the sequence early. One request is in flight
// at a time; the next request is accepted in the cycle after the
// response is loaded, even if it has not been taken yet.
// A stalled receiver holds the response register; a following request
// then waits in its final step until the response is taken.
// Reset clears the coefficients to b0 = 1.0, others 0, and marks every
// channel's delays as zero through per-channel valid bits.
module biquad_filter_section_core
   import bqs_pkg::*;
#(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_data
);

   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CH_EXT_W = 7;

   logic signed [COEF_W-1:0]   coef_ff [NUM_COEFS];
   logic signed [DELAY_W-1:0]  z1_mem [NUM_CHANNELS];
   logic signed [DELAY_W-1:0]  z2_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]    vld_ff;

   logic [CHAN_W-1:0]          ch_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] y_ff;
   logic signed [PROD_W-1:0]   p_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [DELAY_W-1:0]  z1_rd_ff, z2_rd_ff;
   logic                       rd_vld_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;

   logic                       start, advance, busy;
   ucode_type                  ctl;
   cond_type                   cond;
   logic [CH_EXT_W-1:0]        ch_ext;
   logic [AW-1:0]              addr;
   logic signed [SAMPLE_W-1:0] opd;
   logic signed [DELAY_W-1:0]  z1_eff, z2_eff, sat_val;
   logic signed [ACC_W-1:0]    diff;

   assign start     = req_valid && req_ready;
   assign req_ready = !busy;
   assign csr_ready = 1'b1;
   assign advance   = busy && !(ctl.fin && rsp_valid_ff && !rsp_ready);

   assign ch_ext = {{(CH_EXT_W-CHAN_W){1'b0}}, ch_ff};
   assign addr   = ch_ext[AW-1:0];

   assign cond.in_range = ch_ext < CH_EXT_W'(NUM_CHANNELS);
   assign cond.ovf      = acc_ff[ACC_W-2:SAMPLE_W+FRAC_SH-1]
                          != {(ACC_W-SAMPLE_W-FRAC_SH){acc_ff[SAMPLE_W+FRAC_SH-1]}};

   bqs_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .advance (advance),
      .cond    (cond),
      .busy    (busy),
      .ctl     (ctl)
   );

   assign opd    = ctl.opd_y ? y_ff : x_ff;
   assign z1_eff = rd_vld_ff ? z1_rd_ff : '0;
   assign z2_eff = rd_vld_ff ? z2_rd_ff : '0;
   assign diff   = acc_ff - ACC_W'(p_ff);

   always_comb begin
      if (diff[ACC_W-1:DELAY_W-1] == {(ACC_W-DELAY_W+1){diff[ACC_W-1]}}) begin
         sat_val = diff[DELAY_W-1:0];
      end else if (diff[ACC_W-1]) begin
         sat_val = {1'b1, {(DELAY_W-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(DELAY_W-1){1'b1}}};
      end
   end

   always_comb begin
      unique case (ctl.acc_op)
         ACC_P_Z1: acc_in = ACC_W'(p_ff) + ACC_W'(z1_eff);
         ACC_P_Z2: acc_in = ACC_W'(p_ff) + ACC_W'(z2_eff);
         ACC_P:    acc_in = ACC_W'(p_ff);
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[COEF_B0] <= COEF_W'(32'sh0100_0000);
         coef_ff[COEF_B1] <= '0;
         coef_ff[COEF_B2] <= '0;
         coef_ff[COEF_A1] <= '0;
         coef_ff[COEF_A2] <= '0;
      end else if (csr_valid && csr_index < CSR_IDX_W'(NUM_COEFS)) begin
         coef_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ch_ff <= req_payload.chan_index;
         x_ff  <= req_payload.sample_in;
      end
      if (advance) begin
         p_ff   <= opd * coef_ff[ctl.coef_sel];
         acc_ff <= acc_in;
         if (ctl.cap_y) begin
            y_ff <= acc_ff[SAMPLE_W+FRAC_SH-1:FRAC_SH];
         end
         if (ctl.mem_rd) begin
            z1_rd_ff  <= z1_mem[addr];
            z2_rd_ff  <= z2_mem[addr];
            rd_vld_ff <= vld_ff[addr];
         end
         if (ctl.wr_z1) begin
            z1_mem[addr] <= sat_val;
         end
         if (ctl.wr_z2) begin
            z2_mem[addr] <= sat_val;
         end
         if (ctl.wr_zero) begin
            z1_mem[addr] <= '0;
            z2_mem[addr] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance && (ctl.wr_z1 || ctl.wr_zero)) begin
         vld_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && ctl.fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && ctl.fin) begin
         rsp_ff.chan_out   <= ch_ff;
         rsp_ff.sample_out <= ctl.fin_zero ? '0 : y_ff;
         rsp_ff.overflowed <= ctl.fin_ovf;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
